>>> rtl/core/cfps_pkg.sv
package cfps_pkg;

    // fraction bits of the coordinates
    localparam int CoordFracBits = 16;

    // widths and step counts of the shared unit
    localparam int UnitW      = 128;
    localparam int StepW      = 8;
    localparam int DivSteps   = UnitW;
    localparam int SqrtSteps  = 34;
    localparam int SqrtInW    = 2 * SqrtSteps;
    localparam int AbsW       = 33;
    localparam int RootW      = 34;

    // operations of the shared unit
    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } t_op;

    // accumulator selection
    typedef enum logic [1:0] {
        SUM_FX  = 2'd0,
        SUM_FY  = 2'd1,
        SUM_FZ  = 2'd2,
        SUM_POT = 2'd3
    } t_sum_sel;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic [UnitW-1:0] a;
        logic [UnitW-1:0] b;
        logic [UnitW-1:0] c;
        logic [StepW-1:0] steps;
    } t_unit_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [UnitW-1:0] res;
    } t_unit_rsp;

    typedef struct packed {
        logic             add;
        logic             clear;
        t_sum_sel         sel;
        logic             neg;
        logic [UnitW-1:0] mag;
    } t_acc_req;

endpackage

>>> rtl/core/cfps_unit.sv
module cfps_unit import cfps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    logic [UnitW-1:0] r_x;
    logic [UnitW-1:0] r_y;
    logic [UnitW:0]   r_acc;
    logic [StepW-1:0] r_cnt;
    t_op              r_op;
    logic             r_busy;
    logic             r_done;

    logic [UnitW:0]   opnd_a;
    logic [UnitW:0]   opnd_b;
    logic             sub;
    logic [UnitW+1:0] sum;
    logic             no_borrow;

    // operand selection for the one shared adder
    always_comb begin
        case (r_op)
            OP_DIV: begin
                opnd_a = {r_acc[UnitW-1:0], r_x[UnitW-1]};
                opnd_b = {1'b0, r_y};
                sub    = 1'b1;
            end
            OP_SQRT: begin
                opnd_a = {r_acc[UnitW-2:0], r_x[UnitW-1:UnitW-2]};
                opnd_b = {1'b0, r_y[UnitW-3:0], 2'b01};
                sub    = 1'b1;
            end
            default: begin
                opnd_a = r_acc;
                opnd_b = {1'b0, r_x};
                sub    = 1'b0;
            end
        endcase
    end

    assign sum = {1'b0, opnd_a} + {1'b0, (sub ? ~opnd_b : opnd_b)} + {{(UnitW+1){1'b0}}, sub};
    assign no_borrow = sum[UnitW+1];

    // one step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= i_req.steps;
                r_x    <= i_req.a;
                case (i_req.op)
                    OP_MUL: begin
                        r_y   <= i_req.b;
                        r_acc <= {1'b0, i_req.c};
                    end
                    OP_DIV: begin
                        r_y   <= i_req.b;
                        r_acc <= '0;
                    end
                    default: begin
                        r_y   <= '0;
                        r_acc <= '0;
                    end
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == StepW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                case (r_op)
                    OP_DIV: begin
                        r_acc <= no_borrow ? sum[UnitW:0] : opnd_a;
                        r_x   <= {r_x[UnitW-2:0], no_borrow};
                    end
                    OP_SQRT: begin
                        r_acc <= no_borrow ? sum[UnitW:0] : opnd_a;
                        r_y   <= {r_y[UnitW-2:0], no_borrow};
                        r_x   <= {r_x[UnitW-3:0], 2'b00};
                    end
                    default: begin
                        if (r_y[0]) begin
                            r_acc <= {1'b0, sum[UnitW-1:0]};
                        end
                        r_x <= {r_x[UnitW-2:0], 1'b0};
                        r_y <= {1'b0, r_y[UnitW-1:1]};
                    end
                endcase
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = (r_op == OP_DIV)  ? r_x :
                        (r_op == OP_SQRT) ? r_y : r_acc[UnitW-1:0];

endmodule

>>> rtl/core/cfps_acc.sv
module cfps_acc import cfps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_acc_req    i_req,
    output logic [63:0] o_fx,
    output logic [63:0] o_fy,
    output logic [63:0] o_fz,
    output logic [63:0] o_pot,
    output logic        o_sat
);

    localparam logic [63:0] MaxV = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MinV = 64'h8000_0000_0000_0000;

    logic [63:0] r_sum [4];
    logic        r_sat;

    logic [63:0] term;
    logic        term_sat;
    logic [63:0] cur;
    logic [63:0] added;
    logic        ovf;
    logic [63:0] result;

    // clamp the term magnitude to the signed range
    always_comb begin
        term_sat = 1'b0;
        if (i_req.neg) begin
            if (i_req.mag[UnitW-1:64] != '0 || i_req.mag[63:0] > MinV) begin
                term     = MinV;
                term_sat = 1'b1;
            end else begin
                term = -i_req.mag[63:0];
            end
        end else begin
            if (i_req.mag[UnitW-1:63] != '0) begin
                term     = MaxV;
                term_sat = 1'b1;
            end else begin
                term = i_req.mag[63:0];
            end
        end
    end

    // saturating add into the selected sum
    assign cur    = r_sum[i_req.sel];
    assign added  = cur + term;
    assign ovf    = (cur[63] == term[63]) && (added[63] != term[63]);
    assign result = ovf ? (term[63] ? MinV : MaxV) : added;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_sum[0] <= '0;
            r_sum[1] <= '0;
            r_sum[2] <= '0;
            r_sum[3] <= '0;
            r_sat    <= 1'b0;
        end else if (i_req.add) begin
            r_sum[i_req.sel] <= result;
            if (ovf || term_sat) begin
                r_sat <= 1'b1;
            end
        end
    end

    assign o_fx  = r_sum[SUM_FX];
    assign o_fy  = r_sum[SUM_FY];
    assign o_fz  = r_sum[SUM_FZ];
    assign o_pot = r_sum[SUM_POT];
    assign o_sat = r_sat;

endmodule

>>> rtl/core/coulomb_field_potential_sum_top.sv
// an item at zero distance ends after its squared distance is found
// the input is held off while the item is worked, so items are taken one at a time
// any other item is worked by the shared bit-serial unit: five 128-step divides, eight multiplies
// and one square root, run one after another
// reset: synchronous active-low, clears sums, flag, sequencer and output valid
// reset register values: targets 0, coulomb_scale 589008
module coulomb_field_potential_sum_top import cfps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_src_valid,
    output logic        o_src_ready,
    input  logic [31:0] i_src_x,
    input  logic [31:0] i_src_y,
    input  logic [31:0] i_src_z,
    input  logic [31:0] i_charge,
    input  logic        i_last,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [63:0] o_field_x,
    output logic [63:0] o_field_y,
    output logic [63:0] o_field_z,
    output logic [63:0] o_potential,
    output logic        o_overflow
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_SQSUM = 11'b000_0000_0010,
        ST_SQRT  = 11'b000_0000_0100,
        ST_KMUL  = 11'b000_0000_1000,
        ST_PDIV  = 11'b000_0001_0000,
        ST_DMUL  = 11'b000_0010_0000,
        ST_WDIV  = 11'b000_0100_0000,
        ST_FMUL  = 11'b000_1000_0000,
        ST_FDIV  = 11'b001_0000_0000,
        ST_PACC  = 11'b010_0000_0000,
        ST_EMIT  = 11'b100_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        REG_TX    = 2'd0,
        REG_TY    = 2'd1,
        REG_TZ    = 2'd2,
        REG_SCALE = 2'd3
    } t_reg;

    localparam logic [31:0] ScaleReset = 32'd589008;

    // configuration registers
    logic [31:0] r_tx, r_ty, r_tz, r_scale;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx    <= '0;
            r_ty    <= '0;
            r_tz    <= '0;
            r_scale <= ScaleReset;
        end else if (cfg_wr) begin
            case (t_reg'(paddr[3:2]))
                REG_TX:    r_tx    <= pwdata;
                REG_TY:    r_ty    <= pwdata;
                REG_TZ:    r_tz    <= pwdata;
                REG_SCALE: r_scale <= pwdata;
                default:   r_tx    <= r_tx;
            endcase
        end
    end

    always_comb begin
        case (t_reg'(paddr[3:2]))
            REG_TX:    prdata = r_tx;
            REG_TY:    prdata = r_ty;
            REG_TZ:    prdata = r_tz;
            REG_SCALE: prdata = r_scale;
            default:   prdata = '0;
        endcase
    end

    // item capture: offsets from source to target and their magnitudes
    logic [AbsW-1:0] dv [3];
    logic [AbsW-1:0] r_ad [3];
    logic            r_dneg [3];
    logic            r_qneg;
    logic [31:0]     r_qabs;
    logic            r_last;
    logic            accept;

    assign dv[0] = {r_tx[31], r_tx} - {i_src_x[31], i_src_x};
    assign dv[1] = {r_ty[31], r_ty} - {i_src_y[31], i_src_y};
    assign dv[2] = {r_tz[31], r_tz} - {i_src_z[31], i_src_z};

    // sequencer
    t_state           r_state, n_state;
    logic             r_start, n_start;
    logic [1:0]       r_axis;
    logic [UnitW-1:0] r_s;
    logic [RootW-1:0] r_d;
    logic [63:0]      r_k;
    logic [UnitW-1:0] r_pm;
    logic [UnitW-1:0] r_dd;
    logic [UnitW-1:0] r_w;
    logic [UnitW-1:0] r_t;
    logic             emit_go;
    logic             r_res_valid;

    t_unit_req unit_req;
    t_unit_rsp unit_rsp;
    t_acc_req  acc_req;
    logic [63:0] sum_fx, sum_fy, sum_fz, sum_pot;
    logic        sum_sat;

    assign o_src_ready = (r_state == ST_IDLE);
    assign accept      = i_src_valid && o_src_ready;
    assign emit_go     = (r_state == ST_EMIT) && (!r_res_valid || i_res_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept) n_state = ST_SQSUM;
            ST_SQSUM: begin
                if (unit_rsp.done && r_axis == 2'd2) begin
                    if (unit_rsp.res == '0) begin
                        n_state = r_last ? ST_EMIT : ST_IDLE;
                    end else begin
                        n_state = ST_SQRT;
                    end
                end
            end
            ST_SQRT:  if (unit_rsp.done) n_state = ST_KMUL;
            ST_KMUL:  if (unit_rsp.done) n_state = ST_PDIV;
            ST_PDIV:  if (unit_rsp.done) n_state = ST_DMUL;
            ST_DMUL:  if (unit_rsp.done) n_state = ST_WDIV;
            ST_WDIV:  if (unit_rsp.done) n_state = ST_FMUL;
            ST_FMUL:  if (unit_rsp.done) n_state = ST_FDIV;
            ST_FDIV: begin
                if (unit_rsp.done) begin
                    n_state = (r_axis == 2'd2) ? ST_PACC : ST_FMUL;
                end
            end
            ST_PACC:  n_state = r_last ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (emit_go) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
        n_start = (accept || unit_rsp.done) && (n_state != ST_IDLE) &&
                  (n_state != ST_PACC) && (n_state != ST_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= 1'b0;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            if (accept) begin
                r_axis <= '0;
            end else if (unit_rsp.done &&
                         (r_state == ST_SQSUM || r_state == ST_FDIV)) begin
                r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
            end
        end
    end

    // operand and result registers of the item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                r_dneg[i] <= dv[i][AbsW-1];
                r_ad[i]   <= dv[i][AbsW-1] ? -dv[i] : dv[i];
            end
            r_qneg <= i_charge[31];
            r_qabs <= i_charge[31] ? -i_charge : i_charge;
            r_last <= i_last;
            r_s    <= '0;
        end
        if (unit_rsp.done) begin
            case (r_state)
                ST_SQSUM: r_s  <= unit_rsp.res;
                ST_SQRT:  r_d  <= unit_rsp.res[RootW-1:0];
                ST_KMUL:  r_k  <= unit_rsp.res[63:0];
                ST_PDIV:  r_pm <= unit_rsp.res;
                ST_DMUL:  r_dd <= unit_rsp.res;
                ST_WDIV:  r_w  <= unit_rsp.res;
                ST_FMUL:  r_t  <= unit_rsp.res;
                default:  r_t  <= r_t;
            endcase
        end
    end

    // request to the shared unit
    always_comb begin
        unit_req       = '0;
        unit_req.start = r_start;
        case (r_state)
            ST_SQSUM: begin
                unit_req.op    = OP_MUL;
                unit_req.a     = UnitW'(r_ad[r_axis]);
                unit_req.b     = UnitW'(r_ad[r_axis]);
                unit_req.c     = r_s;
                unit_req.steps = StepW'(AbsW);
            end
            ST_SQRT: begin
                unit_req.op    = OP_SQRT;
                unit_req.a     = {r_s[SqrtInW-1:0], {(UnitW-SqrtInW){1'b0}}};
                unit_req.steps = StepW'(SqrtSteps);
            end
            ST_KMUL: begin
                unit_req.op    = OP_MUL;
                unit_req.a     = UnitW'(r_scale);
                unit_req.b     = UnitW'(r_qabs);
                unit_req.steps = StepW'(32);
            end
            ST_PDIV: begin
                unit_req.op    = OP_DIV;
                unit_req.a     = UnitW'(r_k) << CoordFracBits;
                unit_req.b     = UnitW'(r_d);
                unit_req.steps = StepW'(DivSteps);
            end
            ST_DMUL: begin
                unit_req.op    = OP_MUL;
                unit_req.a     = UnitW'(r_d);
                unit_req.b     = UnitW'(r_d);
                unit_req.steps = StepW'(RootW);
            end
            ST_WDIV: begin
                unit_req.op    = OP_DIV;
                unit_req.a     = UnitW'(r_k) << (2 * CoordFracBits);
                unit_req.b     = r_dd;
                unit_req.steps = StepW'(DivSteps);
            end
            ST_FMUL: begin
                unit_req.op    = OP_MUL;
                unit_req.a     = r_w;
                unit_req.b     = UnitW'(r_ad[r_axis]);
                unit_req.steps = StepW'(AbsW);
            end
            ST_FDIV: begin
                unit_req.op    = OP_DIV;
                unit_req.a     = r_t;
                unit_req.b     = UnitW'(r_d);
                unit_req.steps = StepW'(DivSteps);
            end
            default: unit_req.op = OP_MUL;
        endcase
    end

    cfps_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .o_rsp   (unit_rsp)
    );

    // accumulation of field terms and the potential term
    always_comb begin
        acc_req       = '0;
        acc_req.clear = emit_go;
        if (r_state == ST_FDIV) begin
            acc_req.add = unit_rsp.done;
            acc_req.sel = t_sum_sel'(r_axis);
            acc_req.neg = r_qneg ^ r_dneg[r_axis];
            acc_req.mag = unit_rsp.res;
        end else begin
            acc_req.add = (r_state == ST_PACC);
            acc_req.sel = SUM_POT;
            acc_req.neg = r_qneg;
            acc_req.mag = r_pm;
        end
    end

    cfps_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (acc_req),
        .o_fx    (sum_fx),
        .o_fy    (sum_fy),
        .o_fz    (sum_fz),
        .o_pot   (sum_pot),
        .o_sat   (sum_sat)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (emit_go) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            o_field_x   <= sum_fx;
            o_field_y   <= sum_fy;
            o_field_z   <= sum_fz;
            o_potential <= sum_pot;
            o_overflow  <= sum_sat;
        end
    end

    assign o_res_valid = r_res_valid;

    // checks on the sequencer and the shared unit
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_req.start |-> !unit_rsp.busy)
        else $error("unit started while busy");

    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_rsp.busy |-> !o_src_ready)
        else $error("input ready while unit busy");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_go |=> (o_res_valid && sum_fx == '0 && sum_pot == '0 && !sum_sat))
        else $error("result not loaded or sums not cleared");

endmodule
